// ===== src/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Types, sizes and helper functions shared by the escape-time point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  // Sizes of the fixed-point formats and of the count.
  localparam int FRAC_BITS   = 28;
  localparam int COORD_WIDTH = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int INNER_W     = FRAC_BITS + 8;   // Q8.FRAC working values
  localparam int WIDE_W      = INNER_W + 2;     // room for one add before saturation
  localparam int MUL_W       = FRAC_BITS + 3;   // operand once |v| <= 2.0
  localparam int PROD_W      = 2 * MUL_W;
  localparam int XX_W        = FRAC_BITS + 3;   // truncated square, at most 4.0
  localparam int XY_W        = FRAC_BITS + 5;   // doubled cross term, floor rounded
  localparam int RED_W       = 6;
  localparam int GREEN_W     = 8;
  localparam int BLUE_W      = 8;
  localparam int QUO_W       = 8;               // every colour quotient is below 256
  localparam int DIVD_W      = COUNT_WIDTH + QUO_W;
  localparam int STEP_W      = 3;

  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(1000);
  localparam logic [7:0] RED_SCALE   = 8'd55;
  localparam logic [7:0] GREEN_SCALE = 8'd155;
  localparam logic [7:0] BLUE_SCALE  = 8'd255;

  localparam logic signed [INNER_W-1:0] FIX_TWO  = INNER_W'(64'd2 << FRAC_BITS);
  localparam logic signed [INNER_W-1:0] FIX_NTWO = -FIX_TWO;
  localparam logic [XX_W:0]             FIX_FOUR = (XX_W + 1)'(64'd4 << FRAC_BITS);
  localparam logic signed [WIDE_W-1:0]  WIDE_MAX = WIDE_W'((64'd1 << (INNER_W - 1)) - 64'd1);
  localparam logic signed [WIDE_W-1:0]  WIDE_MIN = -WIDE_MAX - WIDE_W'(1);

  // One input beat.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_re;
    logic signed [COORD_WIDTH-1:0] point_im;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic [RED_W-1:0]       red_level;
    logic [GREEN_W-1:0]     green_level;
    logic [BLUE_W-1:0]      blue_level;
  } out_beat_t;

  // A queued point with the limit that was in force when it arrived.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_re;
    logic signed [COORD_WIDTH-1:0] point_im;
    logic [COUNT_WIDTH-1:0]        limit;
    logic                          skip;      // zero limit: no iteration
  } job_t;

  // Finished iteration handed to the colour stage.
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic [COUNT_WIDTH-1:0] limit;
  } done_t;

  // Clamp a widened sum to the Q8 working range.
  function automatic logic signed [INNER_W-1:0] sat_inner(input logic signed [WIDE_W-1:0] v);
    logic signed [INNER_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[INNER_W-1:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[INNER_W-1:0];
    end else begin
      r = v[INNER_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/mbe_front.sv =====
// ----------------------------------------------------------------------------
// mbe_front
// Accepts point beats, tags each with the current limit and a skip flag, and
// holds them in a two-entry queue for the iteration engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire mbe_pkg::in_beat_t                in_data,
  input  wire logic [mbe_pkg::COUNT_WIDTH-1:0]  limit,
  output logic                                  job_valid,
  input  wire logic                             job_ready,
  output mbe_pkg::job_t                         job
);
  import mbe_pkg::*;

  job_t       slot_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;
  job_t       entry;

  // Queue status.
  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = slot_r[rd_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  // Classify the incoming point.
  always_comb begin
    entry.point_re = in_data.point_re;
    entry.point_im = in_data.point_im;
    entry.limit    = limit;
    entry.skip     = (limit == '0);
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= entry;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/mbe_iter.sv =====
// ----------------------------------------------------------------------------
// mbe_iter
// Iteration engine: runs z = z*z + c for one point at a time, each iteration
// a products state, then an escape test and update state.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_iter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire mbe_pkg::job_t job,
  output logic               res_valid,
  input  wire logic          res_ready,
  output mbe_pkg::done_t     res
);
  import mbe_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MULT, S_UPD, S_DONE} state_t;

  state_t                         state_r;
  logic signed [INNER_W-1:0]      x_r;
  logic signed [INNER_W-1:0]      y_r;
  logic signed [COORD_WIDTH-1:0]  cre_r;
  logic signed [COORD_WIDTH-1:0]  cim_r;
  logic [COUNT_WIDTH-1:0]         n_r;
  logic [COUNT_WIDTH-1:0]         lim_r;
  logic [XX_W-1:0]                xx_r;
  logic [XX_W-1:0]                yy_r;
  logic signed [XY_W-1:0]         xy_r;

  logic signed [MUL_W-1:0]        xm;
  logic signed [MUL_W-1:0]        ym;
  logic signed [PROD_W-1:0]       p_xx;
  logic signed [PROD_W-1:0]       p_yy;
  logic signed [PROD_W-1:0]       p_xy;
  logic                           out_of_box;
  logic                           escaped;
  logic signed [WIDE_W-1:0]       nx_w;
  logic signed [WIDE_W-1:0]       ny_w;

  assign job_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.count = n_r;
  assign res.limit = lim_r;

  // Products; operands are only used when both lie within +-2.0.
  assign xm   = $signed(x_r[MUL_W-1:0]);
  assign ym   = $signed(y_r[MUL_W-1:0]);
  assign p_xx = xm * xm;
  assign p_yy = ym * ym;
  assign p_xy = xm * ym;

  // Escape tests and next point.
  assign out_of_box = (x_r > FIX_TWO) || (x_r < FIX_NTWO) ||
                      (y_r > FIX_TWO) || (y_r < FIX_NTWO);
  assign escaped    = ({1'b0, xx_r} + {1'b0, yy_r}) > FIX_FOUR;
  assign nx_w = $signed({{(WIDE_W - XX_W){1'b0}}, xx_r})
              - $signed({{(WIDE_W - XX_W){1'b0}}, yy_r})
              + WIDE_W'(cre_r);
  assign ny_w = WIDE_W'(xy_r) + WIDE_W'(cim_r);

  // Sequencer with its working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            x_r     <= INNER_W'(job.point_re);
            y_r     <= INNER_W'(job.point_im);
            cre_r   <= job.point_re;
            cim_r   <= job.point_im;
            n_r     <= '0;
            lim_r   <= job.limit;
            state_r <= job.skip ? S_DONE : S_MULT;
          end
        end
        S_MULT: begin
          if ((n_r >= lim_r) || out_of_box) begin
            state_r <= S_DONE;
          end else begin
            xx_r    <= p_xx[FRAC_BITS +: XX_W];
            yy_r    <= p_yy[FRAC_BITS +: XX_W];
            xy_r    <= p_xy[FRAC_BITS-1 +: XY_W];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (escaped) begin
            state_r <= S_DONE;
          end else begin
            x_r     <= sat_inner(nx_w);
            y_r     <= sat_inner(ny_w);
            n_r     <= n_r + COUNT_WIDTH'(1);
            state_r <= S_MULT;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/mbe_shade.sv =====
// ----------------------------------------------------------------------------
// mbe_shade
// Colour stage: three restoring dividers, one quotient bit a cycle, scale the
// count to the red, green and blue levels, then an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_shade (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           res_valid,
  output logic                res_ready,
  input  wire mbe_pkg::done_t res,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mbe_pkg::out_beat_t  out_data
);
  import mbe_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUT} state_t;

  state_t                  state_r;
  logic [STEP_W-1:0]       step_r;
  logic [DIVD_W-1:0]       div_r;
  logic [DIVD_W-1:0]       rem_red_r;
  logic [DIVD_W-1:0]       rem_grn_r;
  logic [DIVD_W-1:0]       rem_blu_r;
  logic [QUO_W-1:0]        q_red_r;
  logic [QUO_W-1:0]        q_grn_r;
  logic [QUO_W-1:0]        q_blu_r;
  logic [COUNT_WIDTH-1:0]  count_r;
  logic                    zero_r;
  logic                    out_valid_r;
  out_beat_t               out_r;
  logic                    out_free;
  logic                    put_now;
  logic                    ge_red;
  logic                    ge_grn;
  logic                    ge_blu;

  assign res_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;
  assign put_now   = (state_r == S_PUT) && out_free;

  // Trial subtractions for this quotient bit.
  assign ge_red = rem_red_r >= div_r;
  assign ge_grn = rem_grn_r >= div_r;
  assign ge_blu = rem_blu_r >= div_r;

  // Divider sequence and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (put_now) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (res_valid) begin
            count_r   <= res.count;
            zero_r    <= (res.limit == '0);
            div_r     <= {res.limit, {QUO_W{1'b0}}} >> 1;
            rem_red_r <= DIVD_W'(res.count) * DIVD_W'(RED_SCALE);
            rem_grn_r <= DIVD_W'(res.count) * DIVD_W'(GREEN_SCALE);
            rem_blu_r <= DIVD_W'(res.count) * DIVD_W'(BLUE_SCALE);
            q_red_r   <= '0;
            q_grn_r   <= '0;
            q_blu_r   <= '0;
            step_r    <= '0;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge_red) begin
            rem_red_r <= rem_red_r - div_r;
          end
          if (ge_grn) begin
            rem_grn_r <= rem_grn_r - div_r;
          end
          if (ge_blu) begin
            rem_blu_r <= rem_blu_r - div_r;
          end
          q_red_r <= {q_red_r[QUO_W-2:0], ge_red};
          q_grn_r <= {q_grn_r[QUO_W-2:0], ge_grn};
          q_blu_r <= {q_blu_r[QUO_W-2:0], ge_blu};
          div_r   <= div_r >> 1;
          step_r  <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(QUO_W - 1)) begin
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            out_r.iteration_count <= count_r;
            out_r.red_level       <= zero_r ? '0 : q_red_r[RED_W-1:0];
            out_r.green_level     <= zero_r ? '0 : q_grn_r[GREEN_W-1:0];
            out_r.blue_level      <= zero_r ? '0 : q_blu_r[BLUE_W-1:0];
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time evaluator for one point of the Mandelbrot set with colour ramp.
// ----------------------------------------------------------------------------
// In the iteration engine each iteration has a state for the three products
// and a state for the escape test and update; the returned count is at most
// max_iterations, and a zero limit skips iteration. The colour dividers then
// work overlapped with the next point's iterations; a two-entry queue lets the
// input side keep taking beats while the engine works. max_iterations is
// sampled when each point is accepted.
`default_nettype none

module mandelbrot_escape_time (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire mbe_pkg::in_beat_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output mbe_pkg::out_beat_t                   out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mbe_pkg::COUNT_WIDTH-1:0] cfg_max_iterations
);
  import mbe_pkg::*;

  logic [COUNT_WIDTH-1:0] max_iter_r;
  logic                   job_valid;
  logic                   job_ready;
  job_t                   job;
  logic                   res_valid;
  logic                   res_ready;
  done_t                  res;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RESET;
    end else if (cfg_valid) begin
      max_iter_r <= cfg_max_iterations;
    end
  end

  mbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .limit     (max_iter_r),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  mbe_iter u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  mbe_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/mbe_checker.sv =====
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks on the evaluator's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire mbe_pkg::out_beat_t out_data
);
  import mbe_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Red never passes its full scale.
  a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.red_level <= RED_W'(55))
    else $error("red level above full scale");

  // The three ramps are ordered since they share count and limit.
  a_ramp_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (GREEN_W'(out_data.red_level) <= out_data.green_level) &&
                  (out_data.green_level <= out_data.blue_level))
    else $error("colour ramps out of order");

  // Full blue means the limit was reached, so all channels are full.
  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.blue_level == BLUE_W'(255)) |->
      (out_data.red_level == RED_W'(55)) && (out_data.green_level == GREEN_W'(155)))
    else $error("channels disagree at full scale");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
